// ===== rtl/global_average_pool_core_defines.svh =====
// Assertion macros for the global average pool core.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH
`define GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define GAP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted
`define GAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define GAP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gap_pkg.sv =====
// Shared constants for the global average pool core.
// No dependencies; used by every module of the block.
package gap_pkg;

	// Default widths of a sample and of the plane-size exponent
	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned PLANE_BITS_DEF  = 16;

	// Reset value of the plane size register
	localparam int unsigned PLANE_SIZE_RESET = 1;

	// Entries in the queue between accumulator and divider
	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/global_average_pool_core.sv =====
// Top level of the global average pool core: accumulator, queue and divider.
// Depends on gap_pkg, gap_front, gap_queue, gap_back and the defines header.
//
//  channel   direction  handshake                  payload
//  cfg       in         cfg_valid / cfg_ready      plane_size [PLANE_BITS:0]
//  sample    in         sample_valid / sample_stall sample [SAMPLE_BITS-1:0] signed
//  average   out        average_valid / average_stall average [SAMPLE_BITS-1:0] signed
//
// Samples are taken one per cycle while the two-entry plane queue has room.
// Each finished plane holds the divider through its load, divide and hand-off
// states, so a run of short planes can fill the queue and stall the input. A result
// waiting under average_stall holds the divider; the accumulator runs until q_full.
// Reset is asynchronous, active low; plane size resets to 1, sum and count to 0.
`include "global_average_pool_core_defines.svh"

module global_average_pool_core #(
	parameter int unsigned SAMPLE_BITS = gap_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned PLANE_BITS  = gap_pkg::PLANE_BITS_DEF,
	localparam int unsigned SUM_BITS   = SAMPLE_BITS + PLANE_BITS,
	localparam int unsigned SIZE_BITS  = PLANE_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SIZE_BITS-1:0]   plane_size,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   average_valid,
	input  logic                   average_stall,
	output logic [SAMPLE_BITS-1:0] average
);

	logic                          q_push;
	logic                          q_full;
	logic                          q_pop;
	logic                          q_empty;
	logic [SUM_BITS-1:0]           q_sum_in;
	logic [SIZE_BITS-1:0]          q_size_in;
	logic [SUM_BITS+SIZE_BITS-1:0] q_head;

	gap_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PLANE_BITS  (PLANE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.plane_size   (plane_size),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_sum        (q_sum_in),
		.q_size       (q_size_in)
	);

	gap_queue #(
		.WIDTH (SUM_BITS + SIZE_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({q_sum_in, q_size_in}),
		.full      (q_full),
		.pop       (q_pop),
		.head_data (q_head),
		.empty     (q_empty)
	);

	gap_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PLANE_BITS  (PLANE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_sum         (q_head[SUM_BITS+SIZE_BITS-1:SIZE_BITS]),
		.q_size        (q_head[SIZE_BITS-1:0]),
		.average_valid (average_valid),
		.average_stall (average_stall),
		.average       (average)
	);

	// Never push into a full queue, never pop an empty one
	`GAP_ASSERT_IMP(a_push_not_full, clk, arst_n, q_push, !q_full)
	`GAP_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_empty)
	// A finished plane must be visible to the divider in the next cycle
	`GAP_ASSERT_NEXT(a_push_lands, clk, arst_n, q_push && !q_pop, !q_empty)

endmodule

// ===== rtl/gap_front.sv =====
// Front end: plane size register, accumulator and sample counter.
// Depends on gap_pkg; pushes finished plane sums into gap_queue.
module gap_front #(
	parameter int unsigned SAMPLE_BITS = gap_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned PLANE_BITS  = gap_pkg::PLANE_BITS_DEF,
	localparam int unsigned SUM_BITS   = SAMPLE_BITS + PLANE_BITS,
	localparam int unsigned SIZE_BITS  = PLANE_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SIZE_BITS-1:0]   plane_size,
	// sample stream
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	// queue push side
	input  logic                   q_full,
	output logic                   q_push,
	output logic [SUM_BITS-1:0]    q_sum,
	output logic [SIZE_BITS-1:0]   q_size
);

	logic [SIZE_BITS-1:0] size_q;
	logic [SIZE_BITS-1:0] size_eff;
	logic [SIZE_BITS-1:0] count_q;
	logic [SIZE_BITS-1:0] count_inc;
	logic [SUM_BITS-1:0]  sum_q;
	logic [SUM_BITS-1:0]  sum_add;
	logic                 accept;
	logic                 plane_done;

	// Register writes are taken whenever offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_BITS'(gap_pkg::PLANE_SIZE_RESET);
		end else if (cfg_valid) begin
			size_q <= plane_size;
		end
	end

	// Clamp plane size: zero acts as one, anything above 2^PLANE_BITS saturates
	always_comb begin
		priority if (size_q[PLANE_BITS]) begin
			size_eff = SIZE_BITS'(1) << PLANE_BITS;
		end else if (size_q == '0) begin
			size_eff = SIZE_BITS'(1);
		end else begin
			size_eff = size_q;
		end
	end

	// Advance count (saturating at 2^PLANE_BITS) and sum for the incoming sample
	assign count_inc  = count_q[PLANE_BITS] ? count_q : count_q + SIZE_BITS'(1);
	assign plane_done = (count_inc >= size_eff);
	assign sum_add    = sum_q + {{PLANE_BITS{sample[SAMPLE_BITS-1]}}, sample};

	// Hold samples off while the queue has no room
	assign sample_stall = q_full;
	assign accept       = sample_valid & ~q_full;

	assign q_push = accept & plane_done;
	assign q_sum  = sum_add;
	assign q_size = size_eff;

	// Accumulate; clear both on plane completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (plane_done) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_add;
				count_q <= count_inc;
			end
		end
	end

endmodule

// ===== rtl/gap_queue.sv =====
// Short FIFO carrying finished plane sums and divisors to the divider.
// Depends on gap_pkg for its depth.
module gap_queue #(
	parameter int unsigned WIDTH  = 49,
	localparam int unsigned DEPTH = gap_pkg::QUEUE_DEPTH,
	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (fill_q == CNT_BITS'(DEPTH));
	assign empty     = (fill_q == '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & ~empty;
	assign head_data = entry_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/gap_back.sv =====
// Back end: bit-serial restoring divider and the average output register.
// Depends on gap_pkg; pops plane sums from gap_queue.
module gap_back #(
	parameter int unsigned SAMPLE_BITS = gap_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned PLANE_BITS  = gap_pkg::PLANE_BITS_DEF,
	localparam int unsigned SUM_BITS   = SAMPLE_BITS + PLANE_BITS,
	localparam int unsigned SIZE_BITS  = PLANE_BITS + 1,
	localparam int unsigned CNT_BITS   = $clog2(SUM_BITS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// queue pop side
	input  logic                   q_empty,
	output logic                   q_pop,
	input  logic [SUM_BITS-1:0]    q_sum,
	input  logic [SIZE_BITS-1:0]   q_size,
	// average stream
	output logic                   average_valid,
	input  logic                   average_stall,
	output logic [SAMPLE_BITS-1:0] average
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	logic                   neg_q;
	logic [SIZE_BITS-1:0]   div_q;
	logic [SIZE_BITS-1:0]   rem_q;
	logic [SUM_BITS-1:0]    quo_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   avg_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;

	logic [SUM_BITS-1:0]    sum_mag;
	logic [SIZE_BITS:0]     rem_sh;
	logic                   rem_ge;
	logic [SIZE_BITS:0]     rem_sub;
	logic [SIZE_BITS-1:0]   rem_next;
	logic [SUM_BITS-1:0]    quo_next;
	logic [SAMPLE_BITS-1:0] quo_low;

	assign q_pop         = (state_q == ST_IDLE) & ~q_empty;
	assign average_valid = avg_valid_q;
	assign average       = avg_q;

	// Magnitude of the signed sum; the sign is restored after the divide
	assign sum_mag = q_sum[SUM_BITS-1] ? (~q_sum + SUM_BITS'(1)) : q_sum;

	// One restoring-division step: shift in the next dividend bit, trial subtract
	assign rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
	assign rem_ge   = (rem_sh >= {1'b0, div_q});
	assign rem_sub  = rem_sh - {1'b0, div_q};
	assign rem_next = rem_ge ? rem_sub[SIZE_BITS-1:0] : rem_sh[SIZE_BITS-1:0];
	assign quo_next = {quo_q[SUM_BITS-2:0], rem_ge};
	assign quo_low  = quo_next[SAMPLE_BITS-1:0];

	// Sequence load, divide and hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			div_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			avg_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						neg_q   <= q_sum[SUM_BITS-1];
						div_q   <= q_size;
						rem_q   <= '0;
						quo_q   <= sum_mag;
						cnt_q   <= CNT_BITS'(SUM_BITS - 1);
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (cnt_q == '0) begin
						avg_q       <= neg_q ? (~quo_low + SAMPLE_BITS'(1)) : quo_low;
						avg_valid_q <= 1'b1;
						state_q     <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!average_stall) begin
						avg_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					avg_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
